// ===== design/link_frame_receiver_macros.svh =====
// Assertion macros for the link frame receiver checker.
// Depends on nothing; included by the checker file.
`ifndef LINK_FRAME_RECEIVER_MACROS_SVH
`define LINK_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lfr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lfr check failed");

`endif

// ===== design/lfr_pkg.sv =====
// Shared types and codes for the link frame receiver.
// No dependencies; used by the receiver and its checker.
`timescale 1ns / 1ps

package lfr_pkg;

    localparam int INDEX_WIDTH = 12;
    localparam int COUNT_W     = INDEX_WIDTH + 1;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY  = 3'd4;

    // Control codes
    localparam logic [7:0] C_SET  = 8'h03;
    localparam logic [7:0] C_UA   = 8'h07;
    localparam logic [7:0] C_DISC = 8'h0B;
    localparam logic [7:0] C_RR0  = 8'h05;
    localparam logic [7:0] C_RR1  = 8'h85;
    localparam logic [7:0] C_REJ0 = 8'h01;
    localparam logic [7:0] C_REJ1 = 8'h81;
    localparam logic [7:0] C_I0   = 8'h00;
    localparam logic [7:0] C_I1   = 8'h40;

    // Frame event codes
    localparam logic [3:0] EV_NONE     = 4'd0;
    localparam logic [3:0] EV_SET      = 4'd1;
    localparam logic [3:0] EV_UA       = 4'd2;
    localparam logic [3:0] EV_DISC     = 4'd3;
    localparam logic [3:0] EV_RR0      = 4'd4;
    localparam logic [3:0] EV_RR1      = 4'd5;
    localparam logic [3:0] EV_REJ0     = 4'd6;
    localparam logic [3:0] EV_REJ1     = 4'd7;
    localparam logic [3:0] EV_INFO_OK  = 4'd8;
    localparam logic [3:0] EV_INFO_BAD = 4'd9;

    typedef struct packed {
        logic [3:0]             frame_event;
        logic                   info_seq;
        logic                   payload_valid;
        logic [7:0]             payload_byte;
        logic [INDEX_WIDTH-1:0] payload_index;
    } t_result;

    function automatic logic [3:0] supervisory_event(input logic [7:0] ctrl);
        logic [3:0] ev;
        case (ctrl)
            C_SET:   ev = EV_SET;
            C_UA:    ev = EV_UA;
            C_DISC:  ev = EV_DISC;
            C_RR0:   ev = EV_RR0;
            C_RR1:   ev = EV_RR1;
            C_REJ0:  ev = EV_REJ0;
            C_REJ1:  ev = EV_REJ1;
            default: ev = EV_NONE;
        endcase
        return ev;
    endfunction

endpackage

// ===== design/link_frame_receiver.sv =====
// Link frame receiver: flag hunt, header check, destuffing, payload check.
// Each result is registered when its byte is taken, in the skid stage if stalled.
// Throughput: one byte per cycle; o_in_stall rises only while the skid stage is full.
// The frame state update and the result are both computed from the byte at accept.
// Reset (i_rst_n low, synchronous): hunting, registers back to defaults, no output.
// Depends on lfr_pkg.
`timescale 1ns / 1ps

module link_frame_receiver
    import lfr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // line byte request
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_in_byte,
    // result request
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [3:0]             o_frame_event,
    output logic                   o_info_seq,
    output logic                   o_payload_valid,
    output logic [7:0]             o_payload_byte,
    output logic [INDEX_WIDTH-1:0] o_payload_index
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_HDR,
        PH_DATA0,   // first destuffed byte not seen yet
        PH_DATA1    // one destuffed byte held back as a possible check
    } t_phase;

    localparam logic [COUNT_W-1:0] INDEX_CAP = COUNT_W'(1 << INDEX_WIDTH);

    // configuration
    logic [7:0]         r_flag, r_escape, r_mask, r_address;
    logic [CFG_W-1:0]   r_max_payload;

    // frame state
    t_phase             r_phase,   n_phase;
    logic [7:0]         r_addr_h,  n_addr_h;
    logic [7:0]         r_ctrl_h,  n_ctrl_h;
    logic [7:0]         r_pend,    n_pend;
    logic               r_esc,     n_esc;
    logic [7:0]         r_xor,     n_xor;
    logic [COUNT_W-1:0] r_count,   n_count;

    // output register and skid stage
    logic               r_out_valid, r_skid_valid;
    t_result            r_out, r_skid;
    t_result            n_res;

    logic               in_take;
    logic               out_free;
    logic [COUNT_W-1:0] limit;

    assign in_take    = i_in_valid && !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Payload cap is the smaller of max_payload and the index range.
    assign limit = (COUNT_W'(r_max_payload) < INDEX_CAP) ? COUNT_W'(r_max_payload)
                                                         : INDEX_CAP;

    // ---------------------------------------------------------------
    // Per-byte frame logic
    // ---------------------------------------------------------------
    always_comb begin
        logic               is_flag;
        logic               eff_esc;
        logic [7:0]         eff_xor;
        logic [COUNT_W-1:0] eff_count;
        t_phase             eff_phase;
        logic [7:0]         d;
        logic               is_seq1;

        is_flag = (i_in_byte == r_flag);
        is_seq1 = (r_ctrl_h == C_I1);

        n_phase  = r_phase;
        n_addr_h = r_addr_h;
        n_ctrl_h = r_ctrl_h;
        n_pend   = r_pend;
        n_esc    = r_esc;
        n_xor    = r_xor;
        n_count  = r_count;

        n_res = '0;

        // Entering the payload from the header check starts a fresh frame body.
        if (r_phase == PH_HDR) begin
            eff_esc   = 1'b0;
            eff_xor   = '0;
            eff_count = '0;
            eff_phase = PH_DATA0;
        end else begin
            eff_esc   = r_esc;
            eff_xor   = r_xor;
            eff_count = r_count;
            eff_phase = r_phase;
        end
        d = eff_esc ? (i_in_byte ^ r_mask) : i_in_byte;

        case (r_phase)
            PH_FLAG: begin
                if (is_flag) begin
                    n_phase = PH_FLAG;
                end else if (i_in_byte == r_address) begin
                    n_addr_h = i_in_byte;
                    n_phase  = PH_ADDR;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_ADDR: begin
                if (is_flag) begin
                    n_phase = PH_FLAG;
                end else if (i_in_byte inside {C_SET, C_UA, C_DISC, C_RR0, C_RR1,
                                               C_REJ0, C_REJ1, C_I0, C_I1}) begin
                    n_ctrl_h = i_in_byte;
                    n_phase  = PH_CTRL;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_CTRL: begin
                if (is_flag) begin
                    n_phase = PH_FLAG;
                end else if (i_in_byte == (r_addr_h ^ r_ctrl_h)) begin
                    n_phase = PH_HDR;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_HDR, PH_DATA0, PH_DATA1: begin
                if (r_phase == PH_HDR && is_flag) begin
                    // supervisory report; an empty info frame yields no event
                    n_res.frame_event = supervisory_event(r_ctrl_h);
                    n_phase           = PH_FLAG;
                end else if (r_phase == PH_HDR &&
                             !(r_ctrl_h == C_I0 || r_ctrl_h == C_I1)) begin
                    // data after a supervisory header
                    n_phase = PH_HUNT;
                end else begin
                    n_esc   = eff_esc;
                    n_xor   = eff_xor;
                    n_count = eff_count;
                    n_phase = eff_phase;
                    if (r_phase == PH_HDR) begin
                        n_pend = '0;
                    end
                    if (is_flag) begin
                        // closing flag: dangling escape, no check byte or bad XOR
                        if (eff_esc || eff_phase == PH_DATA0 || eff_xor != 8'h00) begin
                            n_res.frame_event = EV_INFO_BAD;
                        end else begin
                            n_res.frame_event = EV_INFO_OK;
                        end
                        n_esc   = 1'b0;
                        n_phase = PH_FLAG;
                    end else if (!eff_esc && i_in_byte == r_escape) begin
                        n_esc = 1'b1;
                    end else if (eff_phase == PH_DATA1 && eff_count >= limit) begin
                        n_res.frame_event = EV_INFO_BAD;
                        n_esc             = 1'b0;
                        n_phase           = PH_HUNT;
                    end else begin
                        n_esc = 1'b0;
                        if (eff_phase == PH_DATA1) begin
                            // release the held byte, it was not the check
                            n_res.payload_valid = 1'b1;
                            n_res.payload_byte  = r_pend;
                            n_res.payload_index = eff_count[INDEX_WIDTH-1:0];
                            n_count             = eff_count + COUNT_W'(1);
                        end
                        n_xor   = eff_xor ^ d;
                        n_pend  = d;
                        n_phase = PH_DATA1;
                    end
                end
            end
            default: begin
                n_phase = is_flag ? PH_FLAG : PH_HUNT;
            end
        endcase

        if (n_res.frame_event == EV_INFO_OK || n_res.frame_event == EV_INFO_BAD) begin
            n_res.info_seq = is_seq1;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag        <= 8'h7E;
            r_escape      <= 8'h7D;
            r_mask        <= 8'h20;
            r_address     <= 8'h03;
            r_max_payload <= CFG_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FLAG:    r_flag        <= i_cfg_data[7:0];
                CFG_ESCAPE:  r_escape      <= i_cfg_data[7:0];
                CFG_MASK:    r_mask        <= i_cfg_data[7:0];
                CFG_ADDRESS: r_address     <= i_cfg_data[7:0];
                CFG_MAX_PAY: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Frame state, advanced once per accepted byte
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_addr_h <= '0;
            r_ctrl_h <= '0;
            r_pend   <= '0;
            r_esc    <= 1'b0;
            r_xor    <= '0;
            r_count  <= '0;
        end else if (in_take) begin
            r_phase  <= n_phase;
            r_addr_h <= n_addr_h;
            r_ctrl_h <= n_ctrl_h;
            r_pend   <= n_pend;
            r_esc    <= n_esc;
            r_xor    <= n_xor;
            r_count  <= n_count;
        end
    end

    // ---------------------------------------------------------------
    // Output register plus skid: the input side keeps flowing while a
    // result waits, until the skid slot is occupied.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_take;
                end
            end else if (in_take) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end
        if (in_take) begin
            r_skid <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_event   = r_out.frame_event;
    assign o_info_seq      = r_out.info_seq;
    assign o_payload_valid = r_out.payload_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_index = r_out.payload_index;

endmodule

// ===== design/lfr_checker.sv =====
// Port-level checker for the link frame receiver, bound to the top level.
// Depends on lfr_pkg and link_frame_receiver_macros.svh.
`timescale 1ns / 1ps
`include "link_frame_receiver_macros.svh"

module lfr_checker
    import lfr_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [3:0]             o_frame_event,
    input logic                   o_info_seq,
    input logic                   o_payload_valid,
    input logic [7:0]             o_payload_byte,
    input logic [INDEX_WIDTH-1:0] o_payload_index
);

    // a data byte never shares a result with a frame event
    `LFR_ASSERT_NOW(a_data_no_event, i_clk, i_rst_n, o_out_valid && o_payload_valid, o_frame_event == EV_NONE)

    // the sequence bit only accompanies an info report
    `LFR_ASSERT_NOW(a_seq_info_only, i_clk, i_rst_n, o_out_valid && o_info_seq, o_frame_event == EV_INFO_OK || o_frame_event == EV_INFO_BAD)

    // data fields read as zero when no data byte is carried
    `LFR_ASSERT_NOW(a_idle_data_zero, i_clk, i_rst_n, o_out_valid && !o_payload_valid, o_payload_byte == 8'h00 && o_payload_index == '0)

    // a stalled result holds
    `LFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_frame_event) && $stable(o_payload_byte) && $stable(o_payload_index))

endmodule

bind link_frame_receiver lfr_checker u_lfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_frame_event   (o_frame_event),
    .o_info_seq      (o_info_seq),
    .o_payload_valid (o_payload_valid),
    .o_payload_byte  (o_payload_byte),
    .o_payload_index (o_payload_index)
);

// ===== tb/link_frame_receiver_tb.sv =====
// Self-checking testbench for link_frame_receiver: drives line bytes, checks every result.
// Predicts each result with its own frame decoder; depends on lfr_pkg and the receiver RTL.
`timescale 1ns / 1ps

module link_frame_receiver_tb;
    import lfr_pkg::*;

    // Decoder phases of the line tracker below
    typedef enum logic [2:0] {
        RX_HUNT, RX_FLAG, RX_ADDR, RX_CTRL, RX_HDR, RX_DATA0, RX_DATA1
    } t_rx_phase;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = CFG_FLAG;
    logic [CFG_W-1:0]       i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic [7:0]             i_in_byte   = 8'h00;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [3:0]             o_frame_event;
    logic                   o_info_seq;
    logic                   o_payload_valid;
    logic [7:0]             o_payload_byte;
    logic [INDEX_WIDTH-1:0] o_payload_index;

    // Register copies, at their reset values
    logic [7:0]       cfg_flag        = 8'h7E;
    logic [7:0]       cfg_escape      = 8'h7D;
    logic [7:0]       cfg_mask        = 8'h20;
    logic [7:0]       cfg_address     = 8'h03;
    logic [CFG_W-1:0] cfg_max_payload = 13'd1024;

    // Line tracker state
    t_rx_phase   rx_phase   = RX_HUNT;
    logic [7:0]  hdr_addr   = 8'h00;
    logic [7:0]  hdr_ctrl   = 8'h00;
    logic [7:0]  held_data  = 8'h00;   // last destuffed byte, may turn out to be the check
    logic        esc_pending = 1'b0;
    logic [7:0]  check_acc  = 8'h00;
    int unsigned data_count = 0;

    t_result     frame_results[$];     // expected results, oldest first
    logic [7:0]  line_bytes[$];        // raw bytes waiting to go on the line
    logic [7:0]  frame_data[$];        // payload of the frame being built

    bit          tx_gaps_on = 1'b1;
    bit          rx_gaps_on = 1'b1;
    int unsigned rx_hold_cycles = 0;

    int unsigned fail_count = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_seen = 0;
    int unsigned sup_frames = 0;
    int unsigned info_ok = 0;
    int unsigned info_bad = 0;
    int unsigned payload_seen = 0;
    int unsigned settings_applied = 0;

    link_frame_receiver u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_frame_event   (o_frame_event),
        .o_info_seq      (o_info_seq),
        .o_payload_valid (o_payload_valid),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame decoder
    // ------------------------------------------------------------------
    function automatic logic [3:0] ctrl_event(input logic [7:0] c);
        logic [3:0] ev;
        case (c)
            C_SET:   ev = EV_SET;
            C_UA:    ev = EV_UA;
            C_DISC:  ev = EV_DISC;
            C_RR0:   ev = EV_RR0;
            C_RR1:   ev = EV_RR1;
            C_REJ0:  ev = EV_REJ0;
            C_REJ1:  ev = EV_REJ1;
            default: ev = EV_NONE;
        endcase
        return ev;
    endfunction

    function automatic bit is_info_ctrl(input logic [7:0] c);
        return (c == C_I0) || (c == C_I1);
    endfunction

    // One line byte in, one result out; advances the tracker state.
    function automatic t_result decode_line_byte(input logic [7:0] b);
        t_result     r;
        logic [7:0]  d;
        bit          is_flag;
        bit          seq;
        bit          in_body;
        int unsigned limit;
        r = '0;
        seq = (hdr_ctrl == C_I1);
        is_flag = (b == cfg_flag);
        limit = (cfg_max_payload < (1 << INDEX_WIDTH)) ? cfg_max_payload : (1 << INDEX_WIDTH);
        case (rx_phase)
            RX_FLAG: begin
                if (is_flag) begin
                    rx_phase = RX_FLAG;
                end else if (b == cfg_address) begin
                    hdr_addr = b;
                    rx_phase = RX_ADDR;
                end else begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_ADDR: begin
                if (is_flag) begin
                    rx_phase = RX_FLAG;
                end else if (ctrl_event(b) != EV_NONE || is_info_ctrl(b)) begin
                    hdr_ctrl = b;
                    rx_phase = RX_CTRL;
                end else begin
                    rx_phase = RX_HUNT;
                end
            end
            RX_CTRL: begin
                if (is_flag) rx_phase = RX_FLAG;
                else if (b == (hdr_addr ^ hdr_ctrl)) rx_phase = RX_HDR;
                else rx_phase = RX_HUNT;
            end
            RX_HDR, RX_DATA0, RX_DATA1: begin
                in_body = 1'b1;
                if (rx_phase == RX_HDR) begin
                    if (is_flag) begin
                        // supervisory close; an empty info frame gives no event
                        r.frame_event = ctrl_event(hdr_ctrl);
                        rx_phase = RX_FLAG;
                        in_body = 1'b0;
                    end else if (!is_info_ctrl(hdr_ctrl)) begin
                        rx_phase = RX_HUNT;
                        in_body = 1'b0;
                    end else begin
                        held_data = 8'h00;
                        esc_pending = 1'b0;
                        check_acc = 8'h00;
                        data_count = 0;
                        rx_phase = RX_DATA0;
                    end
                end
                if (in_body) begin
                    if (is_flag) begin
                        if (esc_pending || rx_phase == RX_DATA0 || check_acc != 8'h00)
                            r.frame_event = EV_INFO_BAD;
                        else
                            r.frame_event = EV_INFO_OK;
                        esc_pending = 1'b0;
                        rx_phase = RX_FLAG;
                    end else if (!esc_pending && b == cfg_escape) begin
                        esc_pending = 1'b1;
                    end else begin
                        d = esc_pending ? (b ^ cfg_mask) : b;
                        esc_pending = 1'b0;
                        if (rx_phase == RX_DATA1 && data_count >= limit) begin
                            r.frame_event = EV_INFO_BAD;   // payload too long
                            rx_phase = RX_HUNT;
                        end else begin
                            if (rx_phase == RX_DATA1) begin
                                r.payload_valid = 1'b1;
                                r.payload_byte  = held_data;
                                r.payload_index = INDEX_WIDTH'(data_count);
                                data_count++;
                            end
                            check_acc ^= d;
                            held_data = d;
                            rx_phase = RX_DATA1;
                        end
                    end
                end
            end
            default: begin
                rx_phase = is_flag ? RX_FLAG : RX_HUNT;
            end
        endcase
        if (r.frame_event == EV_INFO_OK || r.frame_event == EV_INFO_BAD) r.info_seq = seq;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks each taken result, then predicts each taken byte.
    // Port values read here are the ones from before the edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (frame_results.size() == 0) begin
                    $error("result with no expected result waiting: event %0d", o_frame_event);
                    fail_count++;
                end else begin
                    want = frame_results.pop_front();
                    if (o_frame_event !== want.frame_event) begin
                        $error("frame_event: expected %0d, got %0d",
                               want.frame_event, o_frame_event);
                        fail_count++;
                    end
                    if (o_info_seq !== want.info_seq) begin
                        $error("info_seq: expected %0d, got %0d", want.info_seq, o_info_seq);
                        fail_count++;
                    end
                    if (o_payload_valid !== want.payload_valid) begin
                        $error("payload_valid: expected %0d, got %0d",
                               want.payload_valid, o_payload_valid);
                        fail_count++;
                    end
                    if (o_payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, o_payload_byte);
                        fail_count++;
                    end
                    if (o_payload_index !== want.payload_index) begin
                        $error("payload_index: expected %0d, got %0d",
                               want.payload_index, o_payload_index);
                        fail_count++;
                    end
                    if (want.frame_event == EV_INFO_OK) info_ok++;
                    else if (want.frame_event == EV_INFO_BAD) info_bad++;
                    else if (want.frame_event != EV_NONE) sup_frames++;
                    if (want.payload_valid) payload_seen++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                bytes_taken++;
                frame_results.push_back(decode_line_byte(i_in_byte));
            end
        end
    end

    // Result side: random hold-off per result, or one long counted stall on request
    initial begin : result_sink
        int unsigned pause;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles != 0) begin
                pause = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                pause = rx_gaps_on ? $urandom_range(0, 15) : 0;
            end
            if (pause != 0) begin
                i_out_stall <= 1'b1;
                repeat (pause) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!(i_rst_n && o_out_valid)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offers one byte, after a random gap when tx gaps are on, and returns at the edge that takes it.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) send_byte(line_bytes[i]);
        line_bytes.delete();
    endtask

    // Drop valid and let every expected result drain out.
    task automatic wait_line_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frame_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FLAG:    cfg_flag = val[7:0];
            CFG_ESCAPE:  cfg_escape = val[7:0];
            CFG_MASK:    cfg_mask = val[7:0];
            CFG_ADDRESS: cfg_address = val[7:0];
            CFG_MAX_PAY: cfg_max_payload = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_line_config(input logic [7:0] flag, input logic [7:0] esc,
                                   input logic [7:0] mask, input logic [7:0] addr,
                                   input logic [CFG_W-1:0] max_pay);
        write_reg(CFG_FLAG, CFG_W'(flag));
        write_reg(CFG_ESCAPE, CFG_W'(esc));
        write_reg(CFG_MASK, CFG_W'(mask));
        write_reg(CFG_ADDRESS, CFG_W'(addr));
        write_reg(CFG_MAX_PAY, max_pay);
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Frame building
    // ------------------------------------------------------------------
    function automatic void put(input logic [7:0] b);
        line_bytes.push_back(b);
    endfunction

    function automatic void push_stuffed(input logic [7:0] d);
        if (d == cfg_flag || d == cfg_escape) begin
            put(cfg_escape);
            put(d ^ cfg_mask);
        end else begin
            put(d);
        end
    endfunction

    // Header plus, for information frames, stuffed payload and check.
    // The closing flag is left to the caller.
    function automatic void queue_frame(input logic [7:0] addr, input logic [7:0] ctrl,
                                        input logic [7:0] hdr, input logic [7:0] check_flip);
        logic [7:0] sum;
        sum = 8'h00;
        put(addr);
        put(ctrl);
        put(hdr);
        if (is_info_ctrl(ctrl)) begin
            foreach (frame_data[i]) begin
                push_stuffed(frame_data[i]);
                sum ^= frame_data[i];
            end
            push_stuffed(sum ^ check_flip);
        end
    endfunction

    function automatic void queue_good_frame(input logic [7:0] ctrl);
        queue_frame(cfg_address, ctrl, cfg_address ^ ctrl, 8'h00);
        put(cfg_flag);
    endfunction

    function automatic logic [7:0] control_code(input int unsigned n);
        case (n)
            0: return C_SET;
            1: return C_UA;
            2: return C_DISC;
            3: return C_RR0;
            4: return C_RR1;
            5: return C_REJ0;
            6: return C_REJ1;
            7: return C_I0;
            default: return C_I1;
        endcase
    endfunction

    // Payload bytes lean toward the values that need stuffing.
    function automatic logic [7:0] random_data_byte();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) return cfg_flag;
        if (pick < 24) return cfg_escape;
        if (pick < 28) return cfg_flag ^ cfg_mask;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] reg_byte_choice();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return 8'h00;
        if (pick < 4) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed frames with random content; some noise and broken ones.
    function automatic void queue_random_frame();
        int unsigned kind;
        int unsigned len;
        int unsigned top;
        logic [7:0]  ctrl;
        logic [7:0]  addr;
        logic [7:0]  hdr;
        logic [7:0]  flip;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            len = $urandom_range(1, 6);
            repeat (len) put(8'($urandom_range(0, 255)));
            put(cfg_flag);
            return;
        end
        if ($urandom_range(0, 3) == 0) put(cfg_flag);
        ctrl = control_code($urandom_range(0, 8));
        addr = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255)) : cfg_address;
        hdr  = addr ^ ctrl;
        if ($urandom_range(0, 24) == 0) hdr ^= 8'($urandom_range(1, 255));
        if (is_info_ctrl(ctrl) && kind < 10) begin
            // header only: empty information frame
            put(addr);
            put(ctrl);
            put(hdr);
            put(cfg_flag);
            return;
        end
        frame_data.delete();
        top = (cfg_max_payload + 2 < 40) ? cfg_max_payload + 2 : 40;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, top) : $urandom_range(0, 6);
        repeat (len) frame_data.push_back(random_data_byte());
        flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        queue_frame(addr, ctrl, hdr, flip);
        if (kind < 14) put(cfg_escape);                        // flag right after an escape
        else if (kind < 18) put(8'($urandom_range(0, 255)));   // stray data before the flag
        put(cfg_flag);
    endfunction

    task automatic send_random_bytes(input int unsigned count);
        int unsigned start;
        start = bytes_taken;
        while (bytes_taken - start < count) begin
            queue_random_frame();
            send_line();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every control code at reset settings, back to back with shared flags.
    task automatic test_control_codes();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        put(cfg_flag);
        for (int n = 0; n < 7; n++) queue_good_frame(control_code(n));
        frame_data = '{8'h00, 8'hFF};
        queue_good_frame(C_I0);
        frame_data = '{cfg_flag, cfg_escape, 8'h80};
        queue_good_frame(C_I1);
        send_line();
        wait_line_idle();
    endtask

    task automatic test_header_faults();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        put(8'h55);                                    // stray byte while hunting
        put(cfg_flag);
        put(cfg_flag);                                 // repeated opening flag
        queue_good_frame(C_SET);
        put(cfg_address);
        put(cfg_flag);                                 // flag where control is due
        queue_good_frame(C_UA);
        put(cfg_address);
        put(C_DISC);
        put(cfg_flag);                                 // flag where header check is due
        queue_good_frame(C_DISC);
        put(cfg_address ^ 8'h80);                      // wrong address
        put(C_RR0);
        put(cfg_flag);
        put(cfg_address);
        put(8'h02);                                    // unknown control code
        put(cfg_flag);
        put(cfg_address);
        put(C_REJ0);
        put(cfg_address ^ C_REJ0 ^ 8'h01);             // bad header check
        put(cfg_flag);
        queue_good_frame(C_REJ1);
        send_line();
        wait_line_idle();
    endtask

    task automatic test_payload_cases();
        put(cfg_flag);
        put(cfg_address);                              // empty info frame, no event
        put(C_I0);
        put(cfg_address ^ C_I0);
        put(cfg_flag);
        put(cfg_address);                              // supervisory frame with data
        put(C_SET);
        put(cfg_address ^ C_SET);
        put(8'h11);
        put(cfg_flag);
        put(cfg_flag);
        put(cfg_address);                              // flag right after an escape
        put(C_I1);
        put(cfg_address ^ C_I1);
        put(8'h22);
        put(cfg_escape);
        put(cfg_flag);
        put(cfg_address);                              // lone escape, no data
        put(C_I0);
        put(cfg_address ^ C_I0);
        put(cfg_escape);
        put(cfg_flag);
        frame_data.delete();                           // check byte only
        queue_good_frame(C_I1);
        frame_data = '{8'h41, 8'h7F};                  // wrong check
        queue_frame(cfg_address, C_I0, cfg_address ^ C_I0, 8'h10);
        put(cfg_flag);
        put(cfg_address);                              // escaped ordinary byte
        put(C_I0);
        put(cfg_address ^ C_I0);
        put(cfg_escape);
        put(8'h41 ^ cfg_mask);
        put(8'h41);
        put(cfg_flag);
        send_line();
        wait_line_idle();
    endtask

    // Register extremes, escape equal to flag, and a zero mask.
    task automatic test_config_extremes();
        set_line_config(8'h00, 8'h00, 8'hFF, 8'hFF, 13'd4096);
        put(cfg_flag);
        queue_good_frame(C_RR1);
        frame_data = '{8'h00, 8'hFF, 8'h01};
        queue_good_frame(C_I0);
        send_line();
        send_random_bytes(60);
        wait_line_idle();
        set_line_config(8'hFF, 8'hFF, 8'h00, 8'h00, 13'd1);
        put(cfg_flag);
        frame_data = '{8'hFF};
        queue_good_frame(C_I1);
        send_line();
        send_random_bytes(60);
        wait_line_idle();
    endtask

    task automatic test_payload_limit();
        set_line_config(8'h7E, 8'h7D, 8'h20, 8'h03, 13'd1);
        put(cfg_flag);
        frame_data = '{8'hA5};                         // exactly at the limit
        queue_good_frame(C_I0);
        frame_data = '{8'h01, 8'h02};                  // one past the limit
        queue_good_frame(C_I1);
        put(cfg_flag);
        send_line();
        wait_line_idle();
        write_reg(CFG_MAX_PAY, 13'd0);                 // rejects the first payload byte
        put(cfg_flag);
        frame_data = '{8'h3C};
        queue_good_frame(C_I0);
        put(cfg_flag);
        frame_data.delete();
        queue_good_frame(C_I1);
        send_line();
        wait_line_idle();
        // Largest register value: the cap falls back to the index range
        write_reg(CFG_MAX_PAY, 13'h1FFF);
        put(cfg_flag);
        frame_data.delete();
        repeat (20) frame_data.push_back(random_data_byte());
        queue_good_frame(C_I0);
        send_line();
        wait_line_idle();
    endtask

    // Result side holds off long while bytes keep coming, so the input stalls.
    task automatic test_backpressure();
        set_line_config(8'h7E, 8'h7D, 8'h20, 8'h03, 13'd16);
        tx_gaps_on = 1'b0;
        rx_hold_cycles = 300;
        put(cfg_flag);
        send_line();
        send_random_bytes(120);
        wait_line_idle();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [7:0]       flag;
        logic [7:0]       addr;
        logic [CFG_W-1:0] max_pay;
        for (int p = 0; p < 6; p++) begin
            flag = reg_byte_choice();
            addr = reg_byte_choice();
            if (addr == flag) addr = flag ^ 8'h01;     // keep frames reachable
            max_pay = (p == 5) ? 13'd4096 : CFG_W'($urandom_range(1, 24));
            set_line_config(flag, reg_byte_choice(), reg_byte_choice(), addr, max_pay);
            tx_gaps_on = p[0];
            rx_gaps_on = (p % 3) != 0;
            put(cfg_flag);
            send_line();
            send_random_bytes(220);
            wait_line_idle();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_control_codes();
        test_header_faults();
        test_payload_cases();
        test_config_extremes();
        test_payload_limit();
        test_backpressure();
        test_random_traffic();
        repeat (8) @(posedge i_clk);
        if (frame_results.size() != 0) begin
            $error("%0d expected results never arrived", frame_results.size());
            fail_count++;
        end
        $display("covered %0d line bytes, %0d results: %0d supervisory, %0d info ok, %0d info bad",
                 bytes_taken, results_seen, sup_frames, info_ok, info_bad);
        $display("%0d payload bytes checked over %0d register settings",
                 payload_seen, settings_applied + 1);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
